// ===== hw/rtl/h264fua_pkg.sv =====
`timescale 1ns / 1ps

package h264fua_pkg;

  // Widths of the unit length and of the fragment byte count.
  localparam int SIZE_BITS = 24;
  localparam int FRAG_BITS = 14;

  // Configuration port.
  localparam int CFG_BITS = 14;
  localparam int CFG_INDEX_BITS = 4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SINGLE_LIMIT = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAGMENT_PAYLOAD = CFG_INDEX_BITS'(1);
  localparam logic [CFG_BITS-1:0] SINGLE_LIMIT_RESET = CFG_BITS'(1200);
  localparam logic [CFG_BITS-1:0] FRAGMENT_PAYLOAD_RESET = CFG_BITS'(1186);

  // NAL header and FU-A header fields.
  localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
  localparam logic [7:0] NAL_FNRI_MASK = 8'hE0;
  localparam logic [7:0] FU_A_TYPE = 8'd28;
  localparam logic [7:0] FU_START_BIT = 8'h80;
  localparam logic [7:0] FU_END_BIT = 8'h40;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0]           data_byte;
    logic                 unit_start;
    logic [SIZE_BITS-1:0] unit_size;
    logic                 frame_marker;
    logic [31:0]          rtp_time;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        packet_first;
    logic        packet_final;
    logic [15:0] sequence_number;
    logic        marker_bit;
    logic [31:0] packet_time;
    logic        run_last;
  } result_t;

  // One request after classification: up to three bytes that share one packet.
  typedef struct packed {
    logic [1:0]  last_idx;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic        opens;
    logic        closes;
    logic [15:0] seq;
    logic        marker;
    logic [31:0] stamp;
  } entry_t;

  // Head of the queue as the back sees it.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

// ===== hw/rtl/h264_rtp_fua_packetizer.sv =====
// Path: the first result of an accepted byte passes through the queue and then the output register of the back.
// Throughput: one input byte per cycle while the queue has room; the back sends one result per cycle
// unless result_stall holds it, so a byte that opens an FU-A fragment (three results) holds up the
// input once the two-entry queue between front and back has filled.
// Reset (rst, synchronous): sequence number and unit state cleared, queue emptied,
// single-packet size limit back to 1200 and fragment_payload back to 1186.
`timescale 1ns / 1ps

module h264_rtp_fua_packetizer import h264fua_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  item_t                     item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_t                   result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data
);

  logic   accept;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  entry_t q_entry;
  head_t  q_head;

  // Input requests are held back only while the queue is full.
  assign item_stall = q_full;
  assign accept = item_valid && !item_stall;
  assign cfg_ready = 1'b1;

  h264fua_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .push      (q_push),
    .entry     (q_entry)
  );

  h264fua_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_entry),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full)
  );

  h264fua_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // The front never writes into a full queue.
  assert property (@(posedge clk) disable iff (rst) q_full |-> !q_push)
    else $error("queue written while full");

  // A taken result is followed at once by the next one while the queue holds work.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && q_head.valid) |=> result_valid)
    else $error("bubble in result stream with work queued");

  // A packet's first byte that is not the last result of its request is never marked as the packet end.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.packet_first && !result.run_last) |-> !result.packet_final)
    else $error("FU indicator marked as packet end");

endmodule

// ===== hw/rtl/h264fua_front.sv =====
`timescale 1ns / 1ps

module h264fua_front import h264fua_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  input  logic                      accept,
  input  item_t                     item,
  output logic                      push,
  output entry_t                    entry
);

  localparam int LIM_W = (FRAG_BITS > CFG_BITS) ? FRAG_BITS : CFG_BITS;
  localparam logic [LIM_W-1:0] FRAG_LIMIT = LIM_W'((64'd1 << FRAG_BITS) - 64'd1);

  logic [CFG_BITS-1:0]  single_limit;
  logic [CFG_BITS-1:0]  fragment_payload;

  logic [15:0]          seq_counter;
  logic [7:0]           held_header;
  logic [SIZE_BITS-1:0] remaining;
  logic [FRAG_BITS-1:0] bytes_in_fragment;
  logic                 fragment_mode;
  logic                 held_marker;
  logic [31:0]          held_time;
  logic                 at_first;

  logic [LIM_W-1:0]     cfg_ext;
  logic [FRAG_BITS-1:0] frag_size;
  logic [SIZE_BITS-1:0] rem;
  logic                 live;
  logic                 new_frag;
  logic                 hold;
  logic                 single_byte;
  logic                 frag_byte;
  logic                 frag_head;
  logic                 frag_last;
  logic [FRAG_BITS:0]   bif_inc;
  logic                 frag_close;
  logic [15:0]          seq_prev;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      single_limit <= SINGLE_LIMIT_RESET;
      fragment_payload <= FRAGMENT_PAYLOAD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SINGLE_LIMIT: single_limit <= cfg_data;
        REG_FRAGMENT_PAYLOAD: fragment_payload <= cfg_data;
        default: ;
      endcase
    end
  end

  // Fragment size: zero counts as one, and it saturates at the counter range.
  always_comb begin
    cfg_ext = LIM_W'(fragment_payload);
    if (cfg_ext == '0) begin
      frag_size = FRAG_BITS'(1);
    end else if (cfg_ext > FRAG_LIMIT) begin
      frag_size = FRAG_BITS'(FRAG_LIMIT);
    end else begin
      frag_size = FRAG_BITS'(cfg_ext);
    end
  end

  // Classification of the offered byte.
  always_comb begin
    new_frag = item.unit_size > SIZE_BITS'(single_limit);
    rem = item.unit_start ? item.unit_size : remaining;
    live = rem != '0;
    hold = item.unit_start && new_frag;
    single_byte = live && (item.unit_start ? !new_frag : !fragment_mode);
    frag_byte = live && !item.unit_start && fragment_mode;
    frag_head = frag_byte && (bytes_in_fragment == '0);
    frag_last = rem <= SIZE_BITS'(frag_size);
    bif_inc = (FRAG_BITS + 1)'(bytes_in_fragment) + (FRAG_BITS + 1)'(1);
    frag_close = (bif_inc >= (FRAG_BITS + 1)'(frag_size)) || (rem == SIZE_BITS'(1));
    seq_prev = seq_counter - 16'd1;
  end

  // Build the queue entry for a byte that gives results.
  always_comb begin
    push = accept && (single_byte || frag_byte);
    entry = '0;
    entry.byte0 = item.data_byte;
    if (single_byte) begin
      entry.last_idx = 2'd0;
      entry.opens = item.unit_start;
      entry.closes = rem == SIZE_BITS'(1);
      entry.seq = item.unit_start ? seq_counter : seq_prev;
      entry.marker = item.unit_start ? item.frame_marker : held_marker;
      entry.stamp = item.unit_start ? item.rtp_time : held_time;
    end else if (frag_head) begin
      entry.last_idx = 2'd2;
      entry.byte0 = (held_header & NAL_FNRI_MASK) | FU_A_TYPE;
      entry.byte1 = (held_header & NAL_TYPE_MASK)
                    | (at_first ? FU_START_BIT : 8'h00)
                    | (frag_last ? FU_END_BIT : 8'h00);
      entry.byte2 = item.data_byte;
      entry.opens = 1'b1;
      entry.closes = frag_close;
      entry.seq = seq_counter;
      entry.marker = frag_last;
      entry.stamp = held_time;
    end else begin
      entry.last_idx = 2'd0;
      entry.opens = 1'b0;
      entry.closes = frag_close;
      entry.seq = seq_prev;
      entry.marker = held_marker;
      entry.stamp = held_time;
    end
  end

  // Unit state, advanced on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_counter <= '0;
      held_header <= '0;
      remaining <= '0;
      bytes_in_fragment <= '0;
      fragment_mode <= 1'b0;
      held_marker <= 1'b0;
      held_time <= '0;
      at_first <= 1'b0;
    end else if (accept) begin
      if (live) begin
        remaining <= rem - SIZE_BITS'(1);
      end
      if (item.unit_start) begin
        held_time <= item.rtp_time;
        bytes_in_fragment <= '0;
        fragment_mode <= new_frag;
        held_marker <= item.frame_marker && !new_frag;
        if (hold) begin
          held_header <= item.data_byte;
          at_first <= 1'b1;
        end
      end
      if ((single_byte && item.unit_start) || frag_head) begin
        seq_counter <= seq_counter + 16'd1;
      end
      if (frag_byte) begin
        bytes_in_fragment <= frag_close ? '0 : FRAG_BITS'(bif_inc);
        at_first <= 1'b0;
        if (frag_head) begin
          held_marker <= frag_last;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/h264fua_queue.sv =====
`timescale 1ns / 1ps

module h264fua_queue import h264fua_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  input  logic   pop,
  output head_t  head,
  output logic   full
);

  entry_t                    slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;

  assign full = count == QUEUE_CNT_BITS'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.entry = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                  : wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                  : rd_ptr + QUEUE_PTR_BITS'(1);
      end
      case ({push, pop})
        2'b10: count <= count + QUEUE_CNT_BITS'(1);
        2'b01: count <= count - QUEUE_CNT_BITS'(1);
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/h264fua_back.sv =====
`timescale 1ns / 1ps

module h264fua_back import h264fua_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  head_t   head,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic [1:0] idx;
  logic       load;
  logic       at_end;
  result_t    next_result;

  // Pick the byte at the current index of the head entry.
  always_comb begin
    load = head.valid && (!result_valid || !result_stall);
    at_end = idx == head.entry.last_idx;
    pop = load && at_end;
    next_result.packet_first = head.entry.opens && (idx == 2'd0);
    next_result.packet_final = head.entry.closes && at_end;
    next_result.sequence_number = head.entry.seq;
    next_result.marker_bit = head.entry.marker;
    next_result.packet_time = head.entry.stamp;
    next_result.run_last = at_end;
    case (idx)
      2'd0: next_result.out_byte = head.entry.byte0;
      2'd1: next_result.out_byte = head.entry.byte1;
      default: next_result.out_byte = head.entry.byte2;
    endcase
  end

  // Output register and index into the head entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx <= 2'd0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        idx <= at_end ? 2'd0 : idx + 2'd1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= next_result;
    end
  end

endmodule

// ===== verif/tb_h264_rtp_fua_packetizer.sv =====
`timescale 1ns / 1ps

module tb_h264_rtp_fua_packetizer;
  import h264fua_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PERCENT = 27;
  localparam int LONG_HOLD_CYCLES = 120;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      item_valid = 1'b0;
  logic                      item_stall;
  item_t                     item = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  result_t                   result;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_SINGLE_LIMIT;
  logic [CFG_BITS-1:0]       cfg_data = '0;

  h264_rtp_fua_packetizer DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // NAL bytes waiting to be offered, and payload bytes still to come out.
  item_t   nal_bytes_q [$];
  result_t pkt_bytes_expected [$];

  // Local copy of the packetizer state and of its two limits.
  logic [15:0]           seq_next = '0;
  logic [7:0]            hdr_held = '0;
  logic [SIZE_BITS-1:0]  seen_cnt = '0;
  logic [FRAG_BITS-1:0]  frag_cnt = '0;
  logic [SIZE_BITS-1:0]  unit_len = '0;
  bit                    frag_mode = 1'b0;
  bit                    marker_held = 1'b0;
  logic [31:0]           time_held = '0;
  logic [CFG_BITS-1:0]   cfg_max_size = SINGLE_LIMIT_RESET;
  logic [CFG_BITS-1:0]   cfg_frag_payload = FRAGMENT_PAYLOAD_RESET;

  bit  item_taken = 1'b0;
  bit  calm = 1'b0;
  int  hold_requests = 0;
  int  holds_done = 0;
  int  hold_left = 0;
  int  errors = 0;
  int  items_accepted = 0;
  int  results_checked = 0;
  int  packets_seen = 0;
  int  settings_used = 1;
  int  cycle_cnt = 0;

  function automatic result_t make_pkt_byte(logic [7:0] b, bit first, bit last_of_pkt,
                                            logic [15:0] seq, bit marker);
    result_t r;
    r.out_byte = b;
    r.packet_first = first;
    r.packet_final = last_of_pkt;
    r.sequence_number = seq;
    r.marker_bit = marker;
    r.packet_time = time_held;
    r.run_last = 1'b0;
    return r;
  endfunction

  // Work out the payload bytes that one accepted NAL byte produces.
  task automatic packetize_byte(input item_t it);
    result_t              r [3];
    int                   n;
    bit                   live;
    bit                   fin;
    logic [SIZE_BITS-1:0] p;
    logic [SIZE_BITS-1:0] psize;
    logic [FRAG_BITS-1:0] f;
    logic [7:0]           fu_hdr;
    logic [15:0]          seq;
    n = 0;
    live = 1'b1;
    if (it.unit_start) begin
      unit_len = it.unit_size;
      marker_held = it.frame_marker;
      time_held = it.rtp_time;
      seen_cnt = '0;
      frag_cnt = '0;
      frag_mode = it.unit_size > SIZE_BITS'(cfg_max_size);
      if (unit_len == '0) begin
        live = 1'b0;
      end else if (frag_mode) begin
        // The NAL header is kept back for the FU indicator and FU header.
        hdr_held = it.data_byte;
        marker_held = 1'b0;
        seen_cnt = SIZE_BITS'(1);
        live = 1'b0;
      end
    end else if (seen_cnt >= unit_len) begin
      live = 1'b0;
    end

    if (live && !frag_mode) begin
      // Single NAL unit packet: the bytes pass straight through.
      if (seen_cnt == '0) begin
        seq = seq_next;
        seq_next = seq_next + 16'd1;
      end else begin
        seq = seq_next - 16'd1;
      end
      r[0] = make_pkt_byte(it.data_byte, seen_cnt == '0, seen_cnt + 1 == unit_len, seq,
                           marker_held);
      n = 1;
      seen_cnt = seen_cnt + 1'b1;
    end else if (live) begin
      // FU-A: a new fragment opens with its two header bytes.
      p = seen_cnt - 1'b1;
      psize = unit_len - 1'b1;
      f = (cfg_frag_payload == '0) ? FRAG_BITS'(1) : FRAG_BITS'(cfg_frag_payload);
      if (frag_cnt == '0) begin
        seq = seq_next;
        seq_next = seq_next + 16'd1;
        marker_held = (psize - p) <= f;
        fu_hdr = hdr_held & NAL_TYPE_MASK;
        if (p == '0) fu_hdr = fu_hdr | FU_START_BIT;
        if (marker_held) fu_hdr = fu_hdr | FU_END_BIT;
        r[0] = make_pkt_byte((hdr_held & NAL_FNRI_MASK) | FU_A_TYPE, 1'b1, 1'b0, seq,
                             marker_held);
        r[1] = make_pkt_byte(fu_hdr, 1'b0, 1'b0, seq, marker_held);
        n = 2;
      end else begin
        seq = seq_next - 16'd1;
      end
      frag_cnt = frag_cnt + 1'b1;
      fin = (frag_cnt >= f) || (p + 1 == psize);
      if (fin) frag_cnt = '0;
      r[n] = make_pkt_byte(it.data_byte, 1'b0, fin, seq, marker_held);
      n = n + 1;
      seen_cnt = seen_cnt + 1'b1;
    end

    for (int k = 0; k < n; k++) begin
      if (k == n - 1) r[k].run_last = 1'b1;
      pkt_bytes_expected.insert(pkt_bytes_expected.size(), r[k]);
    end
  endtask

  // Request acceptance and prediction.
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) begin
      packetize_byte(item);
      item_taken = 1'b1;
      items_accepted++;
    end
  end

  // Sender: offers the next pending byte, idling at random between requests.
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      item_taken = 1'b0;
      if (nal_bytes_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        item <= nal_bytes_q.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_stall <= 1'b1;
    end else if (holds_done < hold_requests) begin
      holds_done++;
      hold_left = LONG_HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // Result checking against the oldest expected payload byte.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pkt_bytes_expected.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: byte %02h first %0b final %0b seq %04h",
                   result.out_byte, result.packet_first, result.packet_final,
                   result.sequence_number);
      end else begin
        want = pkt_bytes_expected.pop_front();
        results_checked++;
        if (result.packet_first) packets_seen++;
        if (result.out_byte !== want.out_byte || result.packet_first !== want.packet_first ||
            result.packet_final !== want.packet_final ||
            result.sequence_number !== want.sequence_number ||
            result.marker_bit !== want.marker_bit || result.packet_time !== want.packet_time ||
            result.run_last !== want.run_last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch %0d exp: %02h first %0b final %0b seq %04h mk %0b ts %08h %0b",
                     errors, want.out_byte, want.packet_first, want.packet_final,
                     want.sequence_number, want.marker_bit, want.packet_time, want.run_last);
            $display("mismatch %0d got: %02h first %0b final %0b seq %04h mk %0b ts %08h %0b",
                     errors, result.out_byte, result.packet_first, result.packet_final,
                     result.sequence_number, result.marker_bit, result.packet_time,
                     result.run_last);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_cnt,
               pkt_bytes_expected.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_item(input logic [7:0] b, input bit opens, input logic [23:0] size,
                           input bit marker, input logic [31:0] stamp);
    item_t it;
    it.data_byte = b;
    it.unit_start = opens;
    it.unit_size = size;
    it.frame_marker = marker;
    it.rtp_time = stamp;
    nal_bytes_q.insert(nal_bytes_q.size(), it);
  endtask

  // A run of NAL bytes, opened with the given size or continuing an open unit.
  task automatic queue_unit(input logic [23:0] size, input int nbytes, input bit opens);
    for (int i = 0; i < nbytes; i++)
      push_item(8'($urandom), opens && i == 0, (opens && i == 0) ? size : 24'($urandom),
                1'($urandom_range(0, 1)), $urandom);
  endtask

  // Mostly well-formed units, with empty, cut-short and overlong ones and stray bytes.
  task automatic queue_random_units(input int target);
    int                   added;
    int                   len;
    int                   kind;
    int                   lim;
    logic [SIZE_BITS-1:0] size;
    added = 0;
    while (added < target) begin
      kind = $urandom_range(0, 99);
      lim = 2 * int'(cfg_max_size) + 4;
      if (lim > 24) lim = 24;
      len = $urandom_range(1, lim);
      if (kind < 70) begin
        queue_unit(24'(len), len, 1'b1);
        added += len;
      end else if (kind < 78) begin
        queue_unit('0, $urandom_range(1, 2), 1'b1);
      end else if (kind < 86) begin
        if ($urandom_range(0, 1) == 1) size = 24'($urandom);
        else size = 24'(len + $urandom_range(1, 5));
        queue_unit(size, len, 1'b1);
        added += len;
      end else if (kind < 93) begin
        queue_unit(24'(len), len + $urandom_range(1, 3), 1'b1);
        added += len;
      end else begin
        queue_unit('0, $urandom_range(1, 3), 1'b0);
      end
    end
  endtask

  // Wait until every byte is sent and every expected result has come out.
  task automatic drain_all();
    while (nal_bytes_q.size() != 0) @(posedge clk);
    @(negedge clk);
    while (item_valid || pkt_bytes_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write both limits back to back; called at a falling edge with the block idle.
  task automatic program_limits(input logic [CFG_BITS-1:0] max_size,
                                input logic [CFG_BITS-1:0] frag_bytes);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SINGLE_LIMIT;
    cfg_data <= max_size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_max_size = max_size;
    @(negedge clk);
    cfg_index <= REG_FRAGMENT_PAYLOAD;
    cfg_data <= frag_bytes;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_frag_payload = frag_bytes;
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
    @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Limits as they come out of reset.
    queue_random_units(4);
    drain_all();

    // Directed units with tight limits.
    program_limits(CFG_BITS'(4), CFG_BITS'(2));
    push_item(8'h00, 1'b1, 24'd3, 1'b1, 32'hFFFF_FFFF);
    push_item(8'hFF, 1'b0, '0, 1'b0, '0);
    push_item(8'h5A, 1'b0, '0, 1'b0, '0);
    // A stray byte after a complete unit.
    push_item(8'hA5, 1'b0, '1, 1'b1, '1);
    push_item(8'h12, 1'b1, 24'd1, 1'b0, 32'h0000_0000);
    // An empty unit, whose bytes are all ignored.
    push_item(8'h34, 1'b1, 24'd0, 1'b1, 32'h0000_0001);
    push_item(8'h56, 1'b0, 24'd3, 1'b0, '0);
    // Fragmented unit with an all-ones header, then a byte past its end.
    push_item(8'hFF, 1'b1, 24'd7, 1'b1, 32'hDEAD_BEEF);
    queue_unit('0, 6, 1'b0);
    push_item(8'h00, 1'b0, '0, 1'b0, '0);
    // Units cut short by the next start.
    push_item(8'h00, 1'b1, 24'd9, 1'b0, 32'h8000_0000);
    queue_unit('0, 3, 1'b0);
    push_item(8'h61, 1'b1, 24'hFF_FFFF, 1'b1, 32'h7FFF_FFFF);
    queue_unit('0, 1, 1'b0);
    // Leave a fragment half full across the next register write.
    queue_unit(24'd10, 2, 1'b1);
    drain_all();

    // Shrink the fragment size with a fragment open, then finish the unit.
    program_limits(CFG_BITS'(4), CFG_BITS'(1));
    queue_unit('0, 8, 1'b0);
    queue_random_units(4);
    drain_all();

    // Zero limits: every non-empty unit fragments, one byte per fragment.
    program_limits('0, '0);
    queue_unit(24'd1, 1, 1'b1);
    queue_unit(24'd1, 1, 1'b1);
    queue_random_units(6);
    drain_all();

    // Largest limits, with one unit just above the single-packet size.
    program_limits('1, '1);
    queue_random_units(6);
    queue_unit(24'd16384, 6, 1'b1);
    queue_unit(24'd5, 5, 1'b1);
    drain_all();

    program_limits(CFG_BITS'(1), CFG_BITS'(1));
    queue_random_units(4);
    drain_all();

    // No idling, and one long receiver hold-off so that the input backs up.
    calm = 1'b1;
    program_limits(CFG_BITS'($urandom_range(2, 10)), CFG_BITS'($urandom_range(1, 4)));
    queue_random_units(20);
    hold_requests++;
    drain_all();
    calm = 1'b0;

    program_limits(CFG_BITS'($urandom_range(1, 30)), CFG_BITS'($urandom_range(1, 8)));
    queue_random_units(4);
    drain_all();

    $display("Sent %0d NAL bytes over %0d limit settings, %0d results in %0d packets.",
             items_accepted, settings_used, results_checked, packets_seen);
    $display("Single and FU-A packets, empty, cut-short and overlong units: %0d errors.",
             errors);
    if (errors == 0 && pkt_bytes_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/h264fua_pkg.sv
hw/rtl/h264fua_front.sv
hw/rtl/h264fua_queue.sv
hw/rtl/h264fua_back.sv
hw/rtl/h264_rtp_fua_packetizer.sv
verif/tb_h264_rtp_fua_packetizer.sv
